// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent holds in the cycle after antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// consequent holds in the same cycle as antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/dos_pkg.sv =====
// ----------------------------------------------------------------------------
// dos_pkg
// Types and constants of the DHCP option scanner.
// ----------------------------------------------------------------------------
package dos_pkg;

  localparam logic [7:0] OPT_PAD = 8'd0;
  localparam logic [7:0] OPT_END = 8'd255;

  localparam logic [1:0] REG_TARGET_CODE  = 2'd0;
  localparam logic [1:0] REG_SKIP_BYTES   = 2'd1;
  localparam logic [1:0] REG_EXACT_LENGTH = 2'd2;

  localparam logic [7:0] TARGET_CODE_RST  = 8'd53;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  typedef enum logic [5:0] {
    PH_CODE     = 6'b000001,
    PH_SKIPLEN  = 6'b000010,
    PH_SKIPVAL  = 6'b000100,
    PH_MATCHLEN = 6'b001000,
    PH_VALUE    = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_VALUE    = 3'd0,
    KIND_FOUND    = 3'd1,
    KIND_NOTFOUND = 3'd2,
    KIND_CORRUPT  = 3'd3,
    KIND_BADLEN   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value_byte;
    logic [7:0] value_length;
  } result_t;

endpackage

// ===== sv/dhcp_option_scanner_top.sv =====
// ----------------------------------------------------------------------------
// dhcp_option_scanner_top
// Streaming DHCP option TLV scanner: finds one option code in the options
// payload and emits its value bytes followed by a status beat.
//
//   channel   | dir | beat contents
//   s_axis    | in  | one payload byte, tlast on the final byte
//   m_axis    | out | value byte or status (kind on tuser)
//   cfg       | in  | register write, no read-back
//
// One payload byte per cycle while s_axis_tready is high. The per-byte update
// is a phase register, an 8-bit down counter and combinational compare logic;
// results go into a 4-beat queue. A byte yielding two beats (last value byte
// plus status) writes both queue entries at once; s_axis_tready drops while
// the queue holds more than 2 beats. Reset is asynchronous and needs no
// clearing pass. Output stalls back up only through the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhcp_option_scanner_top
  import dos_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
  input  logic        s_axis_tlast,   // end_of_payload
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] value_byte, [15:8] value_length
  output logic [2:0]  m_axis_tuser    // [2:0] kind
);

  logic [7:0] target_code_q;
  logic [1:0] skip_bytes_q;
  logic [7:0] exact_length_q;

  phase_e     phase_q, phase_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] opt_len_q, opt_len_d;
  logic [1:0] skip_left_q, skip_left_d;
  logic       first_q, first_d;

  result_t    res0, res1;
  logic       push0, push1;

  result_t             fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                in_acc, out_acc;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_code_q  <= TARGET_CODE_RST;
      skip_bytes_q   <= '0;
      exact_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_CODE:  target_code_q  <= cfg_data_i;
        REG_SKIP_BYTES:   skip_bytes_q   <= cfg_data_i[1:0];
        REG_EXACT_LENGTH: exact_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q <= FifoCntW'(FifoDepth - 2));

  // per-byte scan step
  always_comb begin
    logic [7:0] b;
    logic       last;
    b    = s_axis_tdata;
    last = s_axis_tlast;
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    opt_len_d    = opt_len_q;
    skip_left_d  = skip_left_q;
    first_d      = 1'b0;
    res0  = '{kind: KIND_NOTFOUND, value_byte: 8'd0, value_length: 8'd0};
    res1  = '{kind: KIND_NOTFOUND, value_byte: 8'd0, value_length: 8'd0};
    push0 = 1'b0;
    push1 = 1'b0;
    case (phase_q)
      PH_CODE: begin
        if (b == OPT_PAD) begin
          push0 = last;
        end else if (b == OPT_END) begin
          push0   = 1'b1;
          phase_d = PH_DONE;
        end else if (b == target_code_q) begin
          if (last) begin
            push0     = 1'b1;
            res0.kind = first_q ? KIND_NOTFOUND : KIND_CORRUPT;
          end else begin
            phase_d = PH_MATCHLEN;
          end
        end else begin
          if (last) push0 = 1'b1;
          else phase_d = PH_SKIPLEN;
        end
      end
      PH_SKIPLEN: begin
        if (last) begin
          push0 = 1'b1;
        end else begin
          bytes_left_d = b;
          phase_d      = (b == 8'd0) ? PH_CODE : PH_SKIPVAL;
        end
      end
      PH_SKIPVAL: begin
        if (last) begin
          push0 = 1'b1;
        end else begin
          bytes_left_d = bytes_left_q - 8'd1;
          if (bytes_left_q == 8'd1) phase_d = PH_CODE;
        end
      end
      PH_MATCHLEN: begin
        if (last) begin
          push0     = 1'b1;
          res0.kind = KIND_CORRUPT;
        end else if ((exact_length_q != 8'd0 && b != exact_length_q) ||
                     (skip_bytes_q != 2'd0 && b <= {6'd0, skip_bytes_q})) begin
          push0     = 1'b1;
          res0.kind = KIND_BADLEN;
          phase_d   = PH_DONE;
        end else if (b == 8'd0) begin
          push0     = 1'b1;
          res0.kind = KIND_FOUND;
          phase_d   = PH_DONE;
        end else begin
          bytes_left_d = b;
          skip_left_d  = skip_bytes_q;
          opt_len_d    = b - {6'd0, skip_bytes_q};
          phase_d      = PH_VALUE;
        end
      end
      PH_VALUE: begin
        bytes_left_d = bytes_left_q - 8'd1;
        if (skip_left_q != 2'd0) begin
          skip_left_d = skip_left_q - 2'd1;
          if (bytes_left_q == 8'd1) begin
            push0     = 1'b1;
            res0.kind = KIND_FOUND;
            res0.value_length = opt_len_q;
            phase_d   = PH_DONE;
          end else if (last) begin
            push0     = 1'b1;
            res0.kind = KIND_CORRUPT;
          end
        end else begin
          push0           = 1'b1;
          res0.kind       = KIND_VALUE;
          res0.value_byte = b;
          if (bytes_left_q == 8'd1) begin
            push1     = 1'b1;
            res1.kind = KIND_FOUND;
            res1.value_length = opt_len_q;
            phase_d   = PH_DONE;
          end else if (last) begin
            push1     = 1'b1;
            res1.kind = KIND_CORRUPT;
          end
        end
      end
      default: ;
    endcase
    if (last) begin
      phase_d      = PH_CODE;
      bytes_left_d = '0;
      opt_len_d    = '0;
      skip_left_d  = '0;
      first_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_CODE;
      bytes_left_q <= '0;
      opt_len_q    <= '0;
      skip_left_q  <= '0;
      first_q      <= 1'b1;
    end else if (in_acc) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      opt_len_q    <= opt_len_d;
      skip_left_q  <= skip_left_d;
      first_q      <= first_d;
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (in_acc && push0) fifo_q[wr_ptr_q] <= res0;
    if (in_acc && push1) fifo_q[wr_ptr_q + FifoPtrW'(1)] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(in_acc & push0) + FifoPtrW'(in_acc & push1);
      rd_ptr_q <= rd_ptr_q + FifoPtrW'(out_acc);
      cnt_q    <= cnt_q + FifoCntW'(in_acc & push0) + FifoCntW'(in_acc & push1)
                  - FifoCntW'(out_acc);
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {fifo_q[rd_ptr_q].value_length, fifo_q[rd_ptr_q].value_byte};
  assign m_axis_tuser  = fifo_q[rd_ptr_q].kind;

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= FifoCntW'(FifoDepth), "result queue overflow")
  `ASSERT_NEXT(a_last_rearm, in_acc && s_axis_tlast, phase_q == PH_CODE && first_q,
               "scanner not re-armed after final byte")
  `ASSERT_SAME(a_status_clean, m_axis_tvalid && m_axis_tuser != KIND_VALUE,
               m_axis_tdata[7:0] == 8'd0, "status beat carries a value byte")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option scanner testbench
// Feeds DHCP option payloads, mostly well-formed TLV lists with random
// content plus truncated and random-noise payloads, under several register
// settings. A scoreboard predicts value-byte and status beats per accepted
// payload byte and checks every output beat in order. Both stream sides
// stall in random bursts.
// ----------------------------------------------------------------------------
module testbench
  import dos_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pl_byte_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = REG_TARGET_CODE;
  logic [7:0]  cfg_data_i    = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // register copies and scanner state of the predictor
  logic [7:0] cfg_target = TARGET_CODE_RST;
  logic [1:0] cfg_skip   = 2'd0;
  logic [7:0] cfg_exact  = 8'd0;
  phase_e     sc_phase   = PH_CODE;
  logic [7:0] sc_left    = 8'd0;
  logic [7:0] sc_optlen  = 8'd0;
  logic [1:0] sc_skip    = 2'd0;
  logic       sc_first   = 1'b1;

  pl_byte_t   tx_q[$];
  logic [7:0] stage_q[$];
  result_t    want_q[$];
  result_t    head;
  int         queued_cnt = 0;
  int         sent_cnt   = 0;
  int         err_cnt    = 0;
  int         src_pct    = 0;
  int         snk_pct    = 0;
  int         src_gap    = 0;
  int         snk_gap    = 0;
  int         idle_cyc   = 0;

  dhcp_option_scanner_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic push_result(input kind_e k, input logic [7:0] vb, input logic [7:0] vl);
    result_t r;
    r.kind         = k;
    r.value_byte   = vb;
    r.value_length = vl;
    want_q.push_back(r);
  endtask

  task automatic scan_predict(input logic [7:0] b, input logic last);
    logic was_first;
    was_first = sc_first;
    sc_first  = 1'b0;
    case (sc_phase)
      PH_CODE: begin
        if (b == OPT_PAD) begin
          if (last) push_result(KIND_NOTFOUND, 8'd0, 8'd0);
        end else if (b == OPT_END) begin
          push_result(KIND_NOTFOUND, 8'd0, 8'd0);
          sc_phase = PH_DONE;
        end else if (b == cfg_target) begin
          if (last && was_first) push_result(KIND_NOTFOUND, 8'd0, 8'd0);
          else if (last) push_result(KIND_CORRUPT, 8'd0, 8'd0);
          else sc_phase = PH_MATCHLEN;
        end else begin
          if (last) push_result(KIND_NOTFOUND, 8'd0, 8'd0);
          else sc_phase = PH_SKIPLEN;
        end
      end
      PH_SKIPLEN: begin
        if (last) begin
          push_result(KIND_NOTFOUND, 8'd0, 8'd0);
        end else begin
          sc_left  = b;
          sc_phase = (b == 8'd0) ? PH_CODE : PH_SKIPVAL;
        end
      end
      PH_SKIPVAL: begin
        if (last) begin
          push_result(KIND_NOTFOUND, 8'd0, 8'd0);
        end else begin
          sc_left = sc_left - 8'd1;
          if (sc_left == 8'd0) sc_phase = PH_CODE;
        end
      end
      PH_MATCHLEN: begin
        if (last) begin
          push_result(KIND_CORRUPT, 8'd0, 8'd0);
        end else if ((cfg_exact != 8'd0 && b != cfg_exact) ||
                     (cfg_skip != 2'd0 && b <= {6'd0, cfg_skip})) begin
          push_result(KIND_BADLEN, 8'd0, 8'd0);
          sc_phase = PH_DONE;
        end else if (b == 8'd0) begin
          push_result(KIND_FOUND, 8'd0, 8'd0);
          sc_phase = PH_DONE;
        end else begin
          sc_left   = b;
          sc_skip   = cfg_skip;
          sc_optlen = b - {6'd0, cfg_skip};
          sc_phase  = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (sc_skip != 2'd0) sc_skip = sc_skip - 2'd1;
        else push_result(KIND_VALUE, b, 8'd0);
        sc_left = sc_left - 8'd1;
        if (sc_left == 8'd0) begin
          push_result(KIND_FOUND, 8'd0, sc_optlen);
          sc_phase = PH_DONE;
        end else if (last) begin
          push_result(KIND_CORRUPT, 8'd0, 8'd0);
        end
      end
      default: ;
    endcase
    if (last) begin
      sc_phase  = PH_CODE;
      sc_left   = 8'd0;
      sc_optlen = 8'd0;
      sc_skip   = 2'd0;
      sc_first  = 1'b1;
    end
  endtask

  // source side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_predict(s_axis_tdata, s_axis_tlast);
        sent_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (src_pct != 0 && $urandom_range(99) < src_pct) begin
          src_gap = $urandom_range(8);
          s_axis_tvalid <= 1'b0;
        end else if (tx_q.size() != 0) begin
          s_axis_tdata  <= tx_q[0].data;
          s_axis_tlast  <= tx_q[0].last;
          s_axis_tvalid <= 1'b1;
          void'(tx_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result beat: kind %0d data %h", m_axis_tuser, m_axis_tdata);
          err_cnt++;
        end else begin
          head = want_q.pop_front();
          if (m_axis_tuser !== head.kind) begin
            $error("kind: expected %0d, actual %0d", head.kind, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tdata[7:0] !== head.value_byte) begin
            $error("value_byte: expected %0d, actual %0d", head.value_byte,
                   m_axis_tdata[7:0]);
            err_cnt++;
          end
          if (m_axis_tdata[15:8] !== head.value_length) begin
            $error("value_length: expected %0d, actual %0d", head.value_length,
                   m_axis_tdata[15:8]);
            err_cnt++;
          end
        end
      end
      if (snk_gap != 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else if (snk_pct != 0 && $urandom_range(99) < snk_pct) begin
        snk_gap = $urandom_range(8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cyc = 0;
      end else begin
        idle_cyc++;
        if (idle_cyc >= WATCHDOG_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  task automatic flush_stage();
    int i;
    for (i = 0; i < stage_q.size(); i++) begin
      tx_q.push_back('{data: stage_q[i], last: (i == stage_q.size() - 1)});
      queued_cnt++;
    end
    stage_q.delete();
  endtask

  task automatic write_cfg(input logic [7:0] tgt, input logic [1:0] skp,
                           input logic [7:0] exa);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TARGET_CODE;
    cfg_data_i <= tgt;
    @(posedge clk_i);
    cfg_idx_i  <= REG_SKIP_BYTES;
    cfg_data_i <= {6'd0, skp};
    @(posedge clk_i);
    cfg_idx_i  <= REG_EXACT_LENGTH;
    cfg_data_i <= exa;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_target = tgt;
    cfg_skip   = skp;
    cfg_exact  = exa;
  endtask

  // wait until every byte is taken and every result has come out
  task automatic drain();
    while (sent_cnt != queued_cnt || want_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic make_payload();
    int shape;
    int len;
    int cut;
    shape = $urandom_range(99);
    if (shape < 15) begin
      repeat ($urandom_range(12, 1)) stage_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3)) begin
        if ($urandom_range(5) == 0) begin
          stage_q.push_back(OPT_PAD);
        end else begin
          stage_q.push_back(8'($urandom_range(254, 1)));
          len = ($urandom_range(29) == 0) ? $urandom_range(255) : $urandom_range(5);
          stage_q.push_back(8'(len));
          repeat (len) stage_q.push_back(8'($urandom_range(255)));
        end
      end
      if ($urandom_range(3) != 0) begin
        stage_q.push_back(cfg_target);
        case ($urandom_range(5))
          0:       len = cfg_exact;
          1:       len = cfg_skip;
          2:       len = cfg_skip + 1;
          3:       len = 0;
          default: len = $urandom_range(8);
        endcase
        if (cfg_exact != 8'd0 && $urandom_range(1) == 0) len = cfg_exact;
        stage_q.push_back(8'(len));
        repeat (len) stage_q.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(1) == 0) begin
        stage_q.push_back(OPT_END);
        repeat ($urandom_range(2)) stage_q.push_back(8'($urandom_range(255)));
      end
      if (stage_q.size() == 0) stage_q.push_back(8'($urandom_range(255)));
      if (shape < 30) begin
        cut = $urandom_range(stage_q.size(), 1);
        while (stage_q.size() > cut) void'(stage_q.pop_back());
      end
    end
    flush_stage();
  endtask

  initial begin
    int ph;
    int budget;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: target 53, no skip, any length
    stage_q = '{8'd53};                          flush_stage();
    stage_q = '{OPT_PAD, 8'd53};                 flush_stage();
    stage_q = '{8'd53, 8'd2};                    flush_stage();
    stage_q = '{8'd12, 8'd0, 8'd53, 8'd0, OPT_END}; flush_stage();
    stage_q = '{8'd53, 8'd1, 8'd5};              flush_stage();
    stage_q = '{8'd53, 8'd3, 8'hAA, 8'hFF};      flush_stage();
    drain();

    write_cfg(8'd81, 2'd3, 8'd0);
    stage_q = '{8'd81, 8'd3, 8'd0};              flush_stage();
    stage_q = '{8'd81, 8'd4, 8'd1, 8'd2, 8'd3, 8'd9}; flush_stage();
    drain();

    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       write_cfg(8'd53, 2'd0, 8'd0);
        1:       write_cfg(8'd81, 2'd3, 8'd0);
        2:       write_cfg(8'd12, 2'd0, 8'd4);
        3:       write_cfg(OPT_PAD, 2'd1, 8'd0);
        4:       write_cfg(OPT_END, 2'd2, 8'd5);
        5:       write_cfg(8'd1, 2'd1, 8'd255);
        6:       write_cfg(8'd254, 2'd3, 8'd7);
        default: write_cfg(8'($urandom_range(255)), 2'($urandom_range(3)),
                           ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(12)));
      endcase
      case ($urandom_range(3))
        0:       src_pct = 0;
        1:       src_pct = 10;
        2:       src_pct = 30;
        default: src_pct = 60;
      endcase
      case ($urandom_range(3))
        0:       snk_pct = 0;
        1:       snk_pct = 10;
        2:       snk_pct = 30;
        default: snk_pct = 60;
      endcase
      if (ph == 8) begin
        src_pct = 0;
        snk_pct = 0;
      end
      budget = queued_cnt + ((ph == 5) ? 300 : 180);
      while (queued_cnt < budget) make_payload();
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (err_cnt == 0 && want_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/dos_pkg.sv
sv/dhcp_option_scanner_top.sv
sim/testbench.sv
